[rtl/smf_pkg.sv]
`default_nettype none

package smf_pkg;

  // Sample and result width, fixed by the stream format.
  localparam int unsigned SMF_DATA_W = 32;

  // Warm-up skip register.
  localparam int unsigned SMF_SKIP_W = 6;
  localparam logic [SMF_SKIP_W-1:0] SMF_SKIP_RESET = 6'd6;

  // Default half-width of the median window.
  localparam int unsigned SMF_RADIUS_DEF = 5;

endpackage

`default_nettype wire

[rtl/smf_window.sv]
`default_nettype none

module smf_window #(
  parameter int unsigned RADIUS = smf_pkg::SMF_RADIUS_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          shift_i,
  input  wire logic [smf_pkg::SMF_DATA_W-1:0]                sample_i,
  output logic      [2*RADIUS:0][smf_pkg::SMF_DATA_W-1:0]    win_o
);
  import smf_pkg::*;

  localparam int unsigned WinLen = 2 * RADIUS + 1;

  logic [WinLen-1:0][SMF_DATA_W-1:0] win_q;

  // Shift line with the oldest entry at index 0; no reset, entries are only
  // read once the fill count says they have been written.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int i = 0; i < int'(WinLen) - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinLen-1] <= sample_i;
    end
  end

  assign win_o = win_q;

endmodule

`default_nettype wire

[rtl/smf_rank.sv]
`default_nettype none

module smf_rank #(
  parameter int unsigned RADIUS = smf_pkg::SMF_RADIUS_DEF
) (
  input  wire logic [2*RADIUS:0][smf_pkg::SMF_DATA_W-1:0]    win_i,
  input  wire logic [$clog2(2*RADIUS+1)-1:0]                 idx_i,
  output logic                                               hit_o,
  output logic      [smf_pkg::SMF_DATA_W-1:0]                value_o
);
  import smf_pkg::*;

  localparam int unsigned WinLen = 2 * RADIUS + 1;
  localparam int unsigned CntW   = $clog2(WinLen + 1);

  logic [SMF_DATA_W-1:0] cand;
  logic [WinLen-1:0]     lt_vec;
  logic [WinLen-1:0]     le_vec;
  logic [CntW-1:0]       lt_cnt;
  logic [CntW-1:0]       le_cnt;

  assign cand = win_i[idx_i];

  // Compare the candidate against every window entry at once.
  always_comb begin
    for (int j = 0; j < int'(WinLen); j++) begin
      lt_vec[j] = win_i[j] < cand;
      le_vec[j] = win_i[j] <= cand;
    end
  end

  assign lt_cnt = CntW'($countones(lt_vec));
  assign le_cnt = CntW'($countones(le_vec));

  // The candidate is the median when its run of equal values covers rank RADIUS.
  assign hit_o   = (lt_cnt <= CntW'(RADIUS)) && (le_cnt > CntW'(RADIUS));
  assign value_o = cand;

endmodule

`default_nettype wire

[rtl/sliding_median_filter.sv]
`default_nettype none
// Running median spike filter for a stream of 32-bit unsigned samples.
//
// Samples arrive on the s_axis item channel; tuser carries the restart flag,
// which clears the window fill and the warm-up count before that sample is
// handled. The first skip_count samples after reset or a restart are dropped.
// From the sample that fills the window to 2*RADIUS+1 entries on, each
// sample yields one item on m_axis: the median of the window, belonging to
// the sample RADIUS positions back. The skip count is written on the cfg
// channel, which is always ready; write it only while the block is idle.
//
// Each accepted sample past the warm-up is shifted into the window. When a
// median is due, a shared rank unit then tests one window entry per cycle
// against all others until one holds rank RADIUS; that median is loaded
// into the output register once the register is free. s_axis_tready is
// low during the ranking, so no new sample is taken until the median has
// been loaded. The result sits in an output register: a new sample is taken
// while it waits, but a further median is held back until m_axis drains.
// Reset clears the window fill count and the warm-up count and sets
// skip_count to 6.
module sliding_median_filter #(
  parameter int unsigned RADIUS = smf_pkg::SMF_RADIUS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration: skip_count.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [smf_pkg::SMF_SKIP_W-1:0]    cfg_data_i,
  // Sample stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [smf_pkg::SMF_DATA_W-1:0]    s_axis_tdata,  // [31:0] sample
  input  wire logic [0:0]                        s_axis_tuser,  // [0] restart
  // Median stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [smf_pkg::SMF_DATA_W-1:0]    m_axis_tdata   // [31:0] median_value
);
  import smf_pkg::*;

  localparam int unsigned WinLen = 2 * RADIUS + 1;
  localparam int unsigned IdxW   = $clog2(WinLen);
  localparam int unsigned CntW   = $clog2(WinLen + 1);

  typedef enum logic [0:0] {
    StIdle,
    StRank
  } state_e;

  state_e                        state_q, state_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic [CntW-1:0]               fill_q, fill_d;
  logic [SMF_SKIP_W-1:0]         skipped_q, skipped_d;
  logic [SMF_SKIP_W-1:0]         skip_cfg_q, skip_cfg_d;
  logic                          m_valid_q, m_valid_d;
  logic [SMF_DATA_W-1:0]         m_data_q, m_data_d;

  logic                          s_acc;
  logic [CntW-1:0]               eff_fill;
  logic [SMF_SKIP_W-1:0]         eff_skipped;
  logic                          warm;
  logic                          shift_en;
  logic [CntW-1:0]               fill_inc;
  logic                          load;

  logic [WinLen-1:0][SMF_DATA_W-1:0] win;
  logic                          rank_hit;
  logic [SMF_DATA_W-1:0]         rank_value;

  smf_window #(
    .RADIUS (RADIUS)
  ) u_window (
    .clk_i    (clk_i),
    .shift_i  (shift_en),
    .sample_i (s_axis_tdata),
    .win_o    (win)
  );

  smf_rank #(
    .RADIUS (RADIUS)
  ) u_rank (
    .win_i   (win),
    .idx_i   (idx_q),
    .hit_o   (rank_hit),
    .value_o (rank_value)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // A restart clears fill and warm-up count before the sample is looked at.
  assign eff_fill    = s_axis_tuser[0] ? '0 : fill_q;
  assign eff_skipped = s_axis_tuser[0] ? '0 : skipped_q;
  assign warm        = eff_skipped < skip_cfg_q;
  assign shift_en    = s_acc && !warm;
  assign fill_inc    = (eff_fill == CntW'(WinLen)) ? eff_fill : eff_fill + 1'b1;

  // The median moves to the output register only once that register is free.
  assign load = (state_q == StRank) && rank_hit && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    fill_d     = fill_q;
    skipped_d  = skipped_q;
    skip_cfg_d = skip_cfg_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    if (cfg_valid_i) begin
      skip_cfg_d = cfg_data_i;
    end

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_acc) begin
          if (warm) begin
            fill_d    = eff_fill;
            skipped_d = eff_skipped + 1'b1;
          end else begin
            fill_d    = fill_inc;
            skipped_d = eff_skipped;
            if (fill_inc == CntW'(WinLen)) begin
              state_d = StRank;
              idx_d   = '0;
            end
          end
        end
      end
      StRank: begin
        if (load) begin
          m_valid_d = 1'b1;
          m_data_d  = rank_value;
          state_d   = StIdle;
        end else if (!rank_hit) begin
          idx_d = (idx_q == IdxW'(WinLen - 1)) ? '0 : idx_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      idx_q      <= '0;
      fill_q     <= '0;
      skipped_q  <= '0;
      skip_cfg_q <= SMF_SKIP_RESET;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      fill_q     <= fill_d;
      skipped_q  <= skipped_d;
      skip_cfg_q <= skip_cfg_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

[rtl/smf_checker.sv]
`default_nettype none

module smf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [smf_pkg::SMF_DATA_W-1:0]    m_axis_tdata
);

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("median item dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("median value changed while stalled");

  // A new result only comes out of the ranking, when inputs were held off.
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("median appeared without a ranking pass");

  // Accepting a sample never yields a result in the very next cycle.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("median appeared straight after a sample");

endmodule

bind sliding_median_filter smf_checker u_smf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
